// ===== rtl/core/ole_pkg.sv =====
`default_nettype none

package ole_pkg;

    localparam int KEY_W      = 32;
    localparam int INDEX_W    = 5;
    localparam int COUNT_W    = 6;
    localparam int READ_LIMIT = 32;

    typedef logic [3:0]       t_cmd;
    typedef logic [1:0]       t_status;
    typedef logic [3:0]       t_cell_op;
    typedef logic [KEY_W-1:0] t_key;

    // Command codes.
    localparam t_cmd CMD_CLEAR      = 4'd0;
    localparam t_cmd CMD_SORTED_INS = 4'd1;
    localparam t_cmd CMD_INS_FRONT  = 4'd2;
    localparam t_cmd CMD_INS_BACK   = 4'd3;
    localparam t_cmd CMD_DEL_FRONT  = 4'd4;
    localparam t_cmd CMD_DEL_KEY    = 4'd5;
    localparam t_cmd CMD_DEL_BACK   = 4'd6;
    localparam t_cmd CMD_REVERSE    = 4'd7;
    localparam t_cmd CMD_READ_OUT   = 4'd8;

    // Result status codes.
    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;
    localparam t_status ST_FEW   = 2'd3;

    // Operations broadcast to every cell of the chain.
    localparam t_cell_op CELL_HOLD     = 4'd0;
    localparam t_cell_op CELL_SORTED   = 4'd1;
    localparam t_cell_op CELL_FRONT    = 4'd2;
    localparam t_cell_op CELL_BACK     = 4'd3;
    localparam t_cell_op CELL_POP      = 4'd4;
    localparam t_cell_op CELL_DEL_KEY  = 4'd5;
    localparam t_cell_op CELL_REV_STEP = 4'd6;
    localparam t_cell_op CELL_REV_COPY = 4'd7;
    localparam t_cell_op CELL_ROTATE   = 4'd8;

endpackage

`default_nettype wire

// ===== rtl/core/ole_cell.sv =====
`default_nettype none

module ole_cell
    import ole_pkg::*;
#(
    parameter int CW  = 6,
    parameter int IDX = 0
) (
    input  wire logic          i_clk,
    input  wire t_cell_op      i_op,
    input  wire t_key          i_key,
    input  wire t_key          i_head,
    input  wire logic [CW-1:0] i_count,
    input  wire t_key          i_left,
    input  wire t_key          i_right,
    input  wire t_key          i_aux_left,
    input  wire logic          i_seen,
    output t_key               o_value,
    output t_key               o_aux,
    output logic               o_seen
);

    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] IDX_C1 = CW'(IDX + 1);

    t_key r_value, n_value;
    t_key r_aux, n_aux;
    logic valid, hit;

    // A cell holds a live element when its position lies below the count.
    assign valid = IDX_C < i_count;

    always_comb begin
        hit = 1'b0;
        if (valid) begin
            if (i_op == CELL_SORTED) begin
                hit = $signed(r_value) > $signed(i_key);
            end else if (i_op == CELL_DEL_KEY) begin
                hit = r_value == i_key;
            end
        end
    end

    // The seen flag ripples from the front: set once this cell or some earlier cell matched.
    assign o_seen = i_seen | hit;

    always_comb begin
        n_value = r_value;
        n_aux   = r_aux;
        unique case (i_op)
            CELL_SORTED: begin
                if (i_seen) begin
                    n_value = i_left;
                end else if (hit || IDX_C == i_count) begin
                    n_value = i_key;
                end
            end
            CELL_FRONT: n_value = i_left;
            CELL_BACK: begin
                if (IDX_C == i_count) begin
                    n_value = i_key;
                end
            end
            CELL_POP: n_value = i_right;
            CELL_DEL_KEY: begin
                if (i_seen || hit) begin
                    n_value = i_right;
                end
            end
            CELL_REV_STEP: begin
                n_value = i_right;
                n_aux   = i_aux_left;
            end
            CELL_REV_COPY: n_value = r_aux;
            CELL_ROTATE: begin
                n_value = (IDX_C1 == i_count) ? i_head : i_right;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_aux   <= n_aux;
    end

    assign o_value = r_value;
    assign o_aux   = r_aux;

endmodule

`default_nettype wire

// ===== rtl/core/ordered_list_engine_core.sv =====
// Ordered list engine: a bounded list of up to CAPACITY signed 32-bit keys held in a row
// of identical cells, one element per cell, edited by commands. Each cycle every cell may
// take its left or right neighbor's value, the command key, or the head value, so for insert,
// delete, clear and the refused or empty cases the command is registered on acceptance and,
// once the output slot is free, the whole row shifts at once. Delete key and sorted insert
// find their position through a match flag that ripples from the front of the row in that
// same cycle. In reverse, the row is emptied from the front into a second register in each
// cell, one element a cycle, then copied back all at once when the output slot is free. In
// read out the row rotates by one place a cycle while the output side keeps up, and the
// front cell is emitted, so after the command the list is back in its original order.
// Only the first 32 elements are emitted; with a larger capacity the remaining rotations run
// without output. The block takes one command at a time; a new command beat is accepted as
// soon as the previous command's last result is registered, even while that result still
// waits on the output side. Every command returns one result beat with last set, except a
// read out of a non-empty list, which returns one beat per emitted element with last on the
// final one.
`default_nettype none

module ordered_list_engine_core
    import ole_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [3:0]          i_command,
    input  wire logic signed [31:0]  i_item_key,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [1:0]               o_status,
    output logic signed [31:0]       o_item_value,
    output logic [INDEX_W-1:0]       o_item_index,
    output logic [COUNT_W-1:0]       o_list_count,
    output logic                     o_last
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int LIMIT = (CAPACITY < READ_LIMIT) ? CAPACITY : READ_LIMIT;

    localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);
    localparam logic [CW-1:0] LIMIT_C = CW'(LIMIT);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    // Controller states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_REV  = 2'd2;
    localparam logic [1:0] S_READ = 2'd3;

    logic [1:0]    r_state, n_state;
    t_cmd          r_cmd;
    t_key          r_key;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_step, n_step;
    logic          r_out_valid, n_out_valid;

    t_status             r_status, n_status;
    t_key                r_value, n_value;
    logic [INDEX_W-1:0]  r_index, n_index;
    logic [COUNT_W-1:0]  r_list_count, n_list_count;
    logic                r_last, n_last;

    t_cell_op cell_op;
    logic     load;
    logic     slot_free;
    logic     accept;
    logic     full;
    logic     empty;
    logic     emit;
    logic [CW-1:0] read_len;
    logic [CW-1:0] step_inc;

    t_key w_value [CAPACITY];
    t_key w_aux   [CAPACITY];
    logic [CAPACITY:0] w_seen;

    // The cell row. The front cell sees the command key on its left and the head
    // value on its auxiliary input, so pushes at the front and the reverse
    // transfer need no special cases inside the cell.
    assign w_seen[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_key left_v, right_v, aux_left_v;

        if (g == 0) begin : g_front
            assign left_v     = r_key;
            assign aux_left_v = w_value[0];
        end else begin : g_inner
            assign left_v     = w_value[g-1];
            assign aux_left_v = w_aux[g-1];
        end

        if (g == CAPACITY - 1) begin : g_back
            assign right_v = w_value[g];
        end else begin : g_mid
            assign right_v = w_value[g+1];
        end

        ole_cell #(
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_op       (cell_op),
            .i_key      (r_key),
            .i_head     (w_value[0]),
            .i_count    (r_count),
            .i_left     (left_v),
            .i_right    (right_v),
            .i_aux_left (aux_left_v),
            .i_seen     (w_seen[g]),
            .o_value    (w_value[g]),
            .o_aux      (w_aux[g]),
            .o_seen     (w_seen[g+1])
        );
    end

    assign o_in_ready = r_state == S_IDLE;
    assign accept     = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;
    assign full       = r_count == CAP_C;
    assign empty      = r_count == '0;

    // Read out emits at most LIMIT elements but always rotates count places.
    assign read_len = (r_count < LIMIT_C) ? r_count : LIMIT_C;
    assign emit     = r_step < LIMIT_C;
    assign step_inc = r_step + ONE_C;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_step       = r_step;
        cell_op      = CELL_HOLD;
        load         = 1'b0;
        n_status     = ST_DONE;
        n_value      = '0;
        n_index      = '0;
        n_list_count = r_list_count;
        n_last       = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                    case (r_cmd)
                        CMD_CLEAR: n_count = '0;
                        CMD_SORTED_INS, CMD_INS_FRONT, CMD_INS_BACK: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count = r_count + ONE_C;
                                if (r_cmd == CMD_SORTED_INS) begin
                                    cell_op = CELL_SORTED;
                                end else if (r_cmd == CMD_INS_FRONT) begin
                                    cell_op = CELL_FRONT;
                                end else begin
                                    cell_op = CELL_BACK;
                                end
                            end
                        end
                        CMD_DEL_FRONT: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                cell_op = CELL_POP;
                                n_count = r_count - ONE_C;
                            end
                        end
                        CMD_DEL_KEY: begin
                            // No cell moves unless some cell matched.
                            cell_op = CELL_DEL_KEY;
                            if (w_seen[CAPACITY]) begin
                                n_count = r_count - ONE_C;
                            end else begin
                                n_status = ST_EMPTY;
                            end
                        end
                        CMD_DEL_BACK: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - ONE_C;
                            end
                        end
                        CMD_REVERSE: begin
                            if (r_count < TWO_C) begin
                                n_status = ST_FEW;
                            end else begin
                                load    = 1'b0;
                                n_step  = '0;
                                n_state = S_REV;
                            end
                        end
                        CMD_READ_OUT: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                load    = 1'b0;
                                n_step  = '0;
                                n_state = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_list_count = COUNT_W'(n_count);
                end
            end
            S_REV: begin
                if (r_step != r_count) begin
                    cell_op = CELL_REV_STEP;
                    n_step  = step_inc;
                end else if (slot_free) begin
                    cell_op      = CELL_REV_COPY;
                    load         = 1'b1;
                    n_list_count = COUNT_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            S_READ: begin
                if (!emit || slot_free) begin
                    cell_op = CELL_ROTATE;
                    n_step  = step_inc;
                    if (emit) begin
                        load         = 1'b1;
                        n_value      = w_value[0];
                        n_index      = INDEX_W'(r_step);
                        n_list_count = COUNT_W'(r_count);
                        n_last       = step_inc == read_len;
                    end
                    if (step_inc == r_count) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_key <= i_item_key;
        end
        if (load) begin
            r_status     <= n_status;
            r_value      <= n_value;
            r_index      <= n_index;
            r_list_count <= n_list_count;
            r_last       <= n_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_item_value = r_value;
    assign o_item_index = r_index;
    assign o_list_count = r_list_count;
    assign o_last       = r_last;

endmodule

`default_nettype wire

// ===== rtl/core/ole_checker.sv =====
`default_nettype none

module ole_checker
    import ole_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic [3:0]          i_command,
    input wire logic signed [31:0]  i_item_key,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire logic [1:0]          o_status,
    input wire logic signed [31:0]  o_item_value,
    input wire logic [INDEX_W-1:0]  o_item_index,
    input wire logic [COUNT_W-1:0]  o_list_count,
    input wire logic                o_last
);

    // A waiting result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_item_value) && $stable(o_item_index) && $stable(o_last))
        else $error("result beat changed while stalled");

    // One command at a time: ready drops after a command beat is taken.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second command taken while busy");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_list_count <= COUNT_W'(CAPACITY))
        else $error("list count above capacity");

    // Refusals and errors always end a command.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_DONE |-> o_last)
        else $error("error status without last");

    // Only read out gives several beats, and those carry element values.
    a_mid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_status == ST_DONE)
        else $error("non-final beat with error status");

endmodule

bind ordered_list_engine_core ole_checker #(.CAPACITY(CAPACITY)) u_ole_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
    import ole_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes that the block treats as no operation.
    localparam t_cmd FIRST_UNUSED_CMD = 4'd9;
    localparam t_cmd LAST_UNUSED_CMD  = 4'd15;

    localparam int LIST_CAPACITY = 32;
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_PERCENT  = 20;
    // A reverse of a full list is the longest internal pass of the block,
    // so this covers any leftover activity.
    localparam int DRAIN_CYCLES  = 2 * LIST_CAPACITY + 16;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int HOLDOFF_LONG  = 150;

    // One expected result beat, at the widths of the output ports.
    typedef struct packed {
        t_status              status;
        t_key                 value;
        logic [INDEX_W-1:0]   index;
        logic [COUNT_W-1:0]   count;
        logic                 last;
    } t_beat;

    // Every input starts at a known value, with reset asserted from time zero.
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic [3:0]          i_command   = CMD_CLEAR;
    logic signed [31:0]  i_item_key  = '0;
    logic                i_out_ready = 1'b0;

    logic                o_in_ready;
    logic                o_out_valid;
    logic [1:0]          o_status;
    logic signed [31:0]  o_item_value;
    logic [INDEX_W-1:0]  o_item_index;
    logic [COUNT_W-1:0]  o_list_count;
    logic                o_last;

    // Shadow copy of the list contents, front element at index 0.
    logic signed [31:0]  list_keys[$];
    // Result beats predicted but not yet seen on the output side.
    t_beat               pending_beats[$];

    // Shared switches between the test tasks and the two handshake sides.
    bit                  idle_enable      = 1'b1;
    int unsigned         holdoff_request  = 0;
    int unsigned         holdoff_left     = 0;

    // Run statistics.
    int unsigned         error_count      = 0;
    int unsigned         beats_checked    = 0;
    int unsigned         commands_sent    = 0;
    int unsigned         readouts_sent    = 0;
    int unsigned         refused_inserts  = 0;
    int unsigned         deepest_list     = 0;
    int unsigned         input_stalls     = 0;

    ordered_list_engine_core #(
        .CAPACITY     (LIST_CAPACITY)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_item_key   (i_item_key),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_item_value (o_item_value),
        .o_item_index (o_item_index),
        .o_list_count (o_list_count),
        .o_last       (o_last)
    );

    // 2 ns clock period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Builds one expected beat; the count field always reflects the list
    // size after the command has been applied.
    function automatic t_beat make_beat(t_status status, t_key value, int unsigned index,
                                        logic last);
        t_beat beat;
        beat.status = status;
        beat.value  = value;
        beat.index  = index[INDEX_W-1:0];
        beat.count  = COUNT_W'(list_keys.size());
        beat.last   = last;
        return beat;
    endfunction

    // Applies one accepted command to the shadow list and queues the result
    // beats that the block must produce for it.
    function automatic void predict_list_command(t_cmd cmd, t_key key);
        logic signed [31:0] skey;
        logic signed [31:0] flipped[$];
        t_status            status;
        int                 pos;
        int                 total;

        skey   = key;
        status = ST_DONE;
        case (cmd)
            CMD_CLEAR: begin
                list_keys.delete();
            end
            CMD_SORTED_INS, CMD_INS_FRONT, CMD_INS_BACK: begin
                if (list_keys.size() >= LIST_CAPACITY) begin
                    status = ST_FULL;
                    refused_inserts++;
                end else if (cmd == CMD_INS_FRONT) begin
                    list_keys.push_front(skey);
                end else if (cmd == CMD_INS_BACK) begin
                    list_keys.push_back(skey);
                end else begin
                    // The new key goes in front of the first element that is
                    // strictly greater, so equal keys keep arrival order.
                    pos = 0;
                    while (pos < list_keys.size() && !(list_keys[pos] > skey))
                        pos++;
                    list_keys.insert(pos, skey);
                end
            end
            CMD_DEL_FRONT: begin
                if (list_keys.size() == 0)
                    status = ST_EMPTY;
                else
                    void'(list_keys.pop_front());
            end
            CMD_DEL_BACK: begin
                if (list_keys.size() == 0)
                    status = ST_EMPTY;
                else
                    void'(list_keys.pop_back());
            end
            CMD_DEL_KEY: begin
                status = ST_EMPTY;
                for (pos = 0; pos < list_keys.size(); pos++) begin
                    if (list_keys[pos] == skey) begin
                        list_keys.delete(pos);
                        status = ST_DONE;
                        break;
                    end
                end
            end
            CMD_REVERSE: begin
                if (list_keys.size() < 2) begin
                    status = ST_FEW;
                end else begin
                    foreach (list_keys[i])
                        flipped.push_front(list_keys[i]);
                    list_keys = flipped;
                end
            end
            CMD_READ_OUT: begin
                readouts_sent++;
                if (list_keys.size() == 0)
                    status = ST_EMPTY;
            end
            default: begin
            end
        endcase

        if (list_keys.size() > deepest_list)
            deepest_list = list_keys.size();

        if (cmd == CMD_READ_OUT && list_keys.size() != 0) begin
            // One beat per element, capped at the read limit, last on the final one.
            total = (list_keys.size() < READ_LIMIT) ? list_keys.size() : READ_LIMIT;
            for (pos = 0; pos < total; pos++)
                pending_beats.push_back(make_beat(ST_DONE, list_keys[pos], pos,
                                                  pos == total - 1));
        end else begin
            pending_beats.push_back(make_beat(status, '0, 0, 1'b1));
        end
    endfunction

    // Offers one command beat and returns in the time step of its acceptance,
    // so that the next call can keep valid high without a gap. The payload is
    // held until the block takes it; the prediction is made at that edge.
    task automatic send_command(input t_cmd cmd, input t_key key);
        while (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_item_key <= key;
        @(posedge i_clk);
        while (!o_in_ready) begin
            input_stalls++;
            @(posedge i_clk);
        end
        commands_sent++;
        predict_list_command(cmd, key);
    endtask

    // Half the keys come from a narrow pool so that duplicates and matching
    // deletes are common, with a share of extremes and fully random patterns.
    function automatic t_key pick_key();
        int unsigned roll;

        roll = $urandom_range(99);
        if (roll < 50)
            return t_key'($signed($urandom_range(16)) - 8);
        else if (roll < 55)
            return 32'h8000_0000;
        else if (roll < 60)
            return 32'h7FFF_FFFF;
        else
            return $urandom;
    endfunction

    // A delete key beat usually names an element that is present.
    function automatic t_key pick_present_key();
        if (list_keys.size() != 0 && $urandom_range(99) < 70)
            return list_keys[$urandom_range(list_keys.size() - 1)];
        return pick_key();
    endfunction

    // Empty-list behavior: every remove, reverse and read out must report
    // the proper status, with one result beat each.
    task automatic test_empty_list();
        send_command(CMD_CLEAR, '0);
        send_command(CMD_READ_OUT, '0);
        send_command(CMD_DEL_FRONT, '0);
        send_command(CMD_DEL_BACK, '0);
        send_command(CMD_DEL_KEY, '0);
        send_command(CMD_REVERSE, '0);
        send_command(CMD_SORTED_INS, '0);
        // A single element is still too few to reverse.
        send_command(CMD_REVERSE, '0);
    endtask

    // Extreme keys at both ends, sorted placement, reverse,
    // delete by key, missing key, and the unused command codes.
    task automatic test_ordering_and_edits();
        send_command(CMD_INS_FRONT, 32'h8000_0000);
        send_command(CMD_INS_BACK, 32'h7FFF_FFFF);
        send_command(CMD_SORTED_INS, 32'hFFFF_FFFF);
        send_command(CMD_SORTED_INS, '0);
        send_command(CMD_READ_OUT, '0);
        send_command(CMD_REVERSE, '0);
        send_command(CMD_READ_OUT, '0);
        send_command(CMD_DEL_KEY, '0);
        send_command(CMD_DEL_KEY, 32'd12345);
        send_command(CMD_DEL_FRONT, '0);
        send_command(CMD_DEL_BACK, '0);
        send_command(FIRST_UNUSED_CMD, 32'hFFFF_FFFF);
        send_command(LAST_UNUSED_CMD, '0);
        send_command(CMD_READ_OUT, '0);
        send_command(CMD_CLEAR, '0);
        send_command(CMD_READ_OUT, '0);
    endtask

    // Fill the store to capacity, check that every kind of insert is refused,
    // then read out, reverse and trim a full list.
    task automatic test_full_store();
        send_command(CMD_CLEAR, '0);
        while (list_keys.size() < LIST_CAPACITY)
            send_command(CMD_SORTED_INS, pick_key());
        send_command(CMD_SORTED_INS, pick_key());
        send_command(CMD_INS_FRONT, pick_key());
        send_command(CMD_INS_BACK, pick_key());
        send_command(CMD_READ_OUT, '0);
        send_command(CMD_REVERSE, '0);
        send_command(CMD_READ_OUT, '0);
        send_command(CMD_DEL_BACK, '0);
        send_command(CMD_INS_BACK, 32'h7FFF_FFFF);
        send_command(CMD_DEL_KEY, list_keys[LIST_CAPACITY - 1]);
        send_command(CMD_READ_OUT, '0);
    endtask

    // The receiver stops for a long stretch while commands keep coming, so the
    // block must hold its result and refuse further command beats.
    task automatic test_output_backpressure();
        holdoff_request = HOLDOFF_LONG;
        repeat (4)
            send_command(CMD_INS_FRONT, pick_key());
        send_command(CMD_READ_OUT, '0);
        repeat (3)
            send_command(CMD_DEL_KEY, pick_present_key());
        send_command(CMD_READ_OUT, '0);
    endtask

    // Random command stream. Every 40 items the growing flag flips and the two halves
    // of the roll are swapped, which leaves the mix of commands the same in both phases.
    task automatic test_random_traffic(input int unsigned items, input bit with_idling);
        int unsigned n;
        int unsigned roll;
        bit          growing;

        idle_enable = with_idling;
        growing     = 1'b1;
        for (n = 0; n < items; n++) begin
            if (n % 40 == 39)
                growing = !growing;
            roll = $urandom_range(99);
            if (!growing)
                roll = (roll < 50) ? roll + 50 : roll - 50;
            // The same mix in both phases: inserts 45 percent, deletes 34 percent.
            if (roll < 25)
                send_command(CMD_SORTED_INS, pick_key());
            else if (roll < 35)
                send_command(CMD_INS_FRONT, pick_key());
            else if (roll < 45)
                send_command(CMD_INS_BACK, pick_key());
            else if (roll < 55)
                send_command(CMD_READ_OUT, pick_key());
            else if (roll < 62)
                send_command(CMD_REVERSE, pick_key());
            else if (roll < 72)
                send_command(CMD_DEL_FRONT, pick_key());
            else if (roll < 82)
                send_command(CMD_DEL_BACK, pick_key());
            else if (roll < 96)
                send_command(CMD_DEL_KEY, pick_present_key());
            else if (roll < 98)
                send_command(CMD_CLEAR, pick_key());
            else
                send_command(t_cmd'($urandom_range(LAST_UNUSED_CMD, FIRST_UNUSED_CMD)),
                             pick_key());
        end
        idle_enable = 1'b1;
    endtask

    // Output side: random idling, or a long hold-off when a test asks for one.
    // The hold-off is counted down here on each clock edge.
    always @(posedge i_clk) begin
        if (holdoff_left == 0 && holdoff_request != 0) begin
            holdoff_left    = holdoff_request;
            holdoff_request = 0;
        end
        if (holdoff_left != 0) begin
            holdoff_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !(idle_enable && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Result checker: every accepted beat is matched against the oldest
    // prediction, field by field.
    always @(posedge i_clk) begin : check_result
        t_beat want;

        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_beats.size() == 0) begin
                error_count++;
                $error("result beat with no prediction waiting: status %0d value %0d",
                       o_status, o_item_value);
            end else begin
                want = pending_beats.pop_front();
                beats_checked++;
                if (o_status !== want.status) begin
                    error_count++;
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                end
                if (o_item_value !== want.value) begin
                    error_count++;
                    $error("item_value: expected %0d, actual %0d",
                           $signed(want.value), o_item_value);
                end
                if (o_item_index !== want.index) begin
                    error_count++;
                    $error("item_index: expected %0d, actual %0d", want.index, o_item_index);
                end
                if (o_list_count !== want.count) begin
                    error_count++;
                    $error("list_count: expected %0d, actual %0d", want.count, o_list_count);
                end
                if (o_last !== want.last) begin
                    error_count++;
                    $error("last: expected %0d, actual %0d", want.last, o_last);
                end
            end
        end
    end

    // Main sequence: reset once, run each test in turn, drain, and report.
    initial begin : run_tests
        int unsigned waited;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_ordering_and_edits();
        test_full_store();
        test_output_backpressure();
        test_random_traffic(240, 1'b1);
        test_random_traffic(80, 1'b0);

        // The last command beat has been taken; stop offering.
        i_in_valid <= 1'b0;

        waited = 0;
        while (pending_beats.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_beats.size() != 0) begin
            error_count++;
            $error("%0d predicted result beats never arrived", pending_beats.size());
        end

        $display("Sent %0d commands (%0d read outs, %0d refused inserts), checked %0d beats.",
                 commands_sent, readouts_sent, refused_inserts, beats_checked);
        $display("Deepest list held %0d keys; command side waited %0d cycles on the block.",
                 deepest_list, input_stalls);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: the slowest correct run is far shorter than this.
    initial begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
